// ----- sv/running_mean_variance_core_defines.svh -----
// Assertion macros for the running mean and variance core checker.
// Used by rmv_checker.sv; expects clk_i and rst_ni in the including scope.
`ifndef RUNNING_MEAN_VARIANCE_CORE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("running_mean_variance_core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("running_mean_variance_core: next-cycle check failed");

`endif

// ----- sv/rmv_pkg.sv -----
// Package for the running mean and variance core: field widths, defaults,
// microcode types and the control program. No dependencies.
package rmv_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SAMPLE_W    = 32;
  localparam int COUNT_OUT_W = 32;
  localparam int MEAN_W      = 48;
  localparam int SQ_W        = 64;
  localparam int VAR_W       = 64;
  localparam int QUO_W       = 64;
  localparam int HALF_W      = 32;
  localparam int PROD_W      = 128;
  localparam int SHAMT_W     = 7;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] STEP_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK  = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIFF   = 4'd2;
  localparam logic [PC_W-1:0] STEP_WAIT_Q = 4'd3;
  localparam logic [PC_W-1:0] STEP_MEAN   = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIFF2  = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL0   = 4'd6;
  localparam logic [PC_W-1:0] STEP_MUL1   = 4'd7;
  localparam logic [PC_W-1:0] STEP_MUL2   = 4'd8;
  localparam logic [PC_W-1:0] STEP_MUL3   = 4'd9;
  localparam logic [PC_W-1:0] STEP_ACC    = 4'd10;
  localparam logic [PC_W-1:0] STEP_REPORT = 4'd11;
  localparam logic [PC_W-1:0] STEP_WAIT_V = 4'd12;
  localparam logic [PC_W-1:0] STEP_OUT    = 4'd13;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_DIFF,
    OP_MEAN,
    OP_DIFF2,
    OP_MUL,
    OP_ACC,
    OP_VAR,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_FULL,
    C_DIV_BUSY,
    C_LOW_COUNT,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL,
    MUL_HH
  } mul_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    mul_e            mul_sel;
    logic            last;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_NEXT, mul_sel: MUL_LL, last: 1'b0, target: STEP_FETCH};
    case (pc)
      STEP_FETCH: begin
        w.op     = OP_LOAD;
        w.cond   = C_NO_INPUT;
        w.target = STEP_FETCH;
      end
      STEP_CHECK: begin
        w.op     = OP_CHECK;
        w.cond   = C_FULL;
        w.target = STEP_REPORT;
      end
      STEP_DIFF:   w.op = OP_DIFF;
      STEP_WAIT_Q: begin
        w.cond   = C_DIV_BUSY;
        w.target = STEP_WAIT_Q;
      end
      STEP_MEAN:   w.op = OP_MEAN;
      STEP_DIFF2:  w.op = OP_DIFF2;
      STEP_MUL0: begin
        w.op      = OP_MUL;
        w.mul_sel = MUL_LL;
      end
      STEP_MUL1: begin
        w.op      = OP_MUL;
        w.mul_sel = MUL_LH;
      end
      STEP_MUL2: begin
        w.op      = OP_MUL;
        w.mul_sel = MUL_HL;
      end
      STEP_MUL3: begin
        w.op      = OP_MUL;
        w.mul_sel = MUL_HH;
      end
      STEP_ACC:    w.op = OP_ACC;
      STEP_REPORT: begin
        w.op     = OP_VAR;
        w.cond   = C_LOW_COUNT;
        w.target = STEP_OUT;
      end
      STEP_WAIT_V: begin
        w.cond   = C_DIV_BUSY;
        w.target = STEP_WAIT_V;
      end
      STEP_OUT: begin
        w.op     = OP_OUT;
        w.cond   = C_OUT_BUSY;
        w.target = STEP_OUT;
        w.last   = 1'b1;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/rmv_if.sv -----
// Valid/ready channel interfaces for the running mean and variance core.
// Depends on rmv_pkg for the payload widths.
interface rmv_sample_if;
  logic                         valid;
  logic                         ready;
  logic [rmv_pkg::SAMPLE_W-1:0] sample;
  logic                         restart;

  modport source (output valid, sample, restart, input ready);
  modport sink (input valid, sample, restart, output ready);
endinterface

interface rmv_stat_if;
  logic                            valid;
  logic                            ready;
  logic [rmv_pkg::COUNT_OUT_W-1:0] sample_count;
  logic [rmv_pkg::MEAN_W-1:0]      running_mean;
  logic [rmv_pkg::VAR_W-1:0]       sample_variance;
  logic                            variance_valid;
  logic                            count_full;

  modport source (output valid, sample_count, running_mean, sample_variance,
                  variance_valid, count_full, input ready);
  modport sink (input valid, sample_count, running_mean, sample_variance,
                variance_valid, count_full, output ready);
endinterface

// ----- sv/rmv_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, shared by the core.
// Depends on rmv_pkg for the quotient width.
module rmv_div #(
  parameter int DIVISOR_W = rmv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rmv_pkg::QUO_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]      divisor_i,
  output logic                      busy_o,
  output logic [rmv_pkg::QUO_W-1:0] quotient_o
);

  localparam int QW    = rmv_pkg::QUO_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dsr_q;
  logic [QW-1:0]        quo_q;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 qbit;
  logic [DIVISOR_W-1:0] rem_d;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  always_comb begin
    rem_sh  = {rem_q, quo_q[QW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    qbit    = (rem_sh >= {1'b0, dsr_q});
    rem_d   = qbit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(QW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], qbit};
    end
  end

endmodule

// ----- sv/running_mean_variance_core.sv -----
// Running mean and sample variance of one series of timing samples (Welford update).
// Depends on rmv_pkg, rmv_if.sv (rmv_sample_if, rmv_stat_if) and rmv_div.
//
// Usage:
//   samp_i carries one sample and a restart flag per transaction; restart clears
//   count, mean and sum of squares before that sample is taken. stat_o returns
//   one result per accepted sample: count, mean (FRACTION_BITS fraction bits),
//   sample variance (2*FRACTION_BITS fraction bits), variance_valid and count_full.
//   A microcode program steps through a small datapath with one shared
//   one-bit-per-cycle divider that forms a 64-bit quotient for the mean
//   update and another for the variance. The statistics update is skipped
//   when the count is full, and the variance division while the count is below two.
//   samp_i.ready is high only in the fetch step, so one item is in flight at a
//   time; the next is taken the cycle after the result is registered.
//   If stat_o stalls, the result register holds and the program waits at the
//   output step; an item already accepted still runs to that step.
//   Reset clears the statistics, the result valid flag and the program counter.
module running_mean_variance_core #(
  parameter int SAMPLE_WIDTH  = rmv_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH   = rmv_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = rmv_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmv_sample_if.sink    samp_i,
  rmv_stat_if.source    stat_o
);

  localparam int CW     = COUNT_WIDTH;
  localparam int MW     = rmv_pkg::MEAN_W;
  localparam int SQW    = rmv_pkg::SQ_W;
  localparam int QW     = rmv_pkg::QUO_W;
  localparam int HW     = rmv_pkg::HALF_W;
  localparam int PW     = rmv_pkg::PROD_W;
  localparam int SV_W   = (SAMPLE_WIDTH < rmv_pkg::SAMPLE_W) ? SAMPLE_WIDTH
                                                              : rmv_pkg::SAMPLE_W;
  localparam int XW     = SV_W + FRACTION_BITS;
  localparam int DW     = (XW > MW) ? XW : MW;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
  localparam logic [MW-1:0] MEAN_MAX  = {MW{1'b1}};

  logic [rmv_pkg::PC_W-1:0] pc_q;
  logic [rmv_pkg::PC_W-1:0] pc_d;
  rmv_pkg::ctrl_t           cw;
  logic                     jump;

  logic [XW-1:0]  x_q;
  logic [CW-1:0]  count_q;
  logic [MW-1:0]  mean_q;
  logic [SQW-1:0] ss_q;
  logic           full_q;
  logic           lt_q;
  logic [DW-1:0]  d_q;
  logic [DW-1:0]  d2_q;
  logic [PW-1:0]  acc_q;

  logic                      out_valid_q;
  logic [rmv_pkg::COUNT_OUT_W-1:0] cnt_out_q;
  logic [MW-1:0]             mean_out_q;
  logic [rmv_pkg::VAR_W-1:0] var_out_q;
  logic                      vv_out_q;
  logic                      full_out_q;

  logic          accept;
  logic          out_busy;
  logic          count_is_full;
  logic          low_count;
  logic [XW-1:0] x_new;
  logic [DW-1:0] x_ext;
  logic [DW-1:0] m_ext;
  logic          x_lt_m;
  logic [DW-1:0] d_abs;
  logic [DW-1:0] q_step;
  logic [DW:0]   sum_up;
  logic [MW-1:0] mean_up;
  logic [MW-1:0] mean_dn;
  logic [QW-1:0] a64;
  logic [QW-1:0] b64;
  logic [HW-1:0] ha;
  logic [HW-1:0] hb;
  logic [rmv_pkg::SHAMT_W-1:0] shamt;
  logic [2*HW-1:0] pp;
  logic [PW-1:0]   pp_sh;
  logic [SQW-1:0]  prod_sat;
  logic [SQW:0]    ss_sum;

  logic          div_start;
  logic [QW-1:0] div_dividend;
  logic [CW-1:0] div_divisor;
  logic          div_busy;
  logic [QW-1:0] div_quo;

  assign cw            = rmv_pkg::prog_word(pc_q);
  assign samp_i.ready  = (pc_q == rmv_pkg::STEP_FETCH);
  assign accept        = samp_i.valid && samp_i.ready;
  assign out_busy      = out_valid_q && !stat_o.ready;
  assign count_is_full = (count_q == COUNT_MAX);
  assign low_count     = (count_q < CW'(2));

  always_comb begin
    case (cw.cond)
      rmv_pkg::C_NEXT:      jump = 1'b0;
      rmv_pkg::C_ALWAYS:    jump = 1'b1;
      rmv_pkg::C_NO_INPUT:  jump = !samp_i.valid;
      rmv_pkg::C_FULL:      jump = count_is_full;
      rmv_pkg::C_DIV_BUSY:  jump = div_busy;
      rmv_pkg::C_LOW_COUNT: jump = low_count;
      rmv_pkg::C_OUT_BUSY:  jump = out_busy;
      default:              jump = 1'b0;
    endcase
    if (jump) begin
      pc_d = cw.target;
    end else if (cw.last) begin
      pc_d = rmv_pkg::STEP_FETCH;
    end else begin
      pc_d = pc_q + rmv_pkg::PC_W'(1);
    end
  end

  always_comb begin
    x_new   = XW'(samp_i.sample[SV_W-1:0]) << FRACTION_BITS;
    x_ext   = DW'(x_q);
    m_ext   = DW'(mean_q);
    x_lt_m  = (x_ext < m_ext);
    d_abs   = x_lt_m ? (m_ext - x_ext) : (x_ext - m_ext);
    q_step  = div_quo[DW-1:0];
    sum_up  = {1'b0, m_ext} + {1'b0, q_step};
    mean_up = (sum_up[DW:MW] != '0) ? MEAN_MAX : sum_up[MW-1:0];
    mean_dn = mean_q - q_step[MW-1:0];
  end

  always_comb begin
    a64 = QW'(d_q);
    b64 = QW'(d2_q);
    case (cw.mul_sel)
      rmv_pkg::MUL_LL: begin
        ha    = a64[HW-1:0];
        hb    = b64[HW-1:0];
        shamt = rmv_pkg::SHAMT_W'(0);
      end
      rmv_pkg::MUL_LH: begin
        ha    = a64[HW-1:0];
        hb    = b64[QW-1:HW];
        shamt = rmv_pkg::SHAMT_W'(HW);
      end
      rmv_pkg::MUL_HL: begin
        ha    = a64[QW-1:HW];
        hb    = b64[HW-1:0];
        shamt = rmv_pkg::SHAMT_W'(HW);
      end
      rmv_pkg::MUL_HH: begin
        ha    = a64[QW-1:HW];
        hb    = b64[QW-1:HW];
        shamt = rmv_pkg::SHAMT_W'(2 * HW);
      end
      default: begin
        ha    = '0;
        hb    = '0;
        shamt = '0;
      end
    endcase
    pp       = ha * hb;
    pp_sh    = PW'(pp) << shamt;
    prod_sat = (acc_q[PW-1:SQW] != '0) ? {SQW{1'b1}} : acc_q[SQW-1:0];
    ss_sum   = {1'b0, ss_q} + {1'b0, prod_sat};
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = QW'(d_abs);
    div_divisor  = count_q;
    case (cw.op)
      rmv_pkg::OP_DIFF: div_start = 1'b1;
      rmv_pkg::OP_VAR: begin
        div_start    = !low_count;
        div_dividend = ss_q;
        div_divisor  = count_q - CW'(1);
      end
      default: ;
    endcase
  end

  rmv_div #(
    .DIVISOR_W (CW)
  ) u_rmv_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rmv_pkg::STEP_FETCH;
      count_q     <= '0;
      mean_q      <= '0;
      ss_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      case (cw.op)
        rmv_pkg::OP_LOAD: begin
          if (accept && samp_i.restart) begin
            count_q <= '0;
            mean_q  <= '0;
            ss_q    <= '0;
          end
        end
        rmv_pkg::OP_CHECK: begin
          full_q <= count_is_full;
          if (!count_is_full) begin
            count_q <= count_q + CW'(1);
          end
        end
        rmv_pkg::OP_MEAN: mean_q <= lt_q ? mean_dn : mean_up;
        rmv_pkg::OP_ACC:  ss_q   <= ss_sum[SQW] ? {SQW{1'b1}} : ss_sum[SQW-1:0];
        default: ;
      endcase
      if (cw.op == rmv_pkg::OP_OUT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (stat_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cw.op)
      rmv_pkg::OP_LOAD: begin
        if (accept) begin
          x_q <= x_new;
        end
      end
      rmv_pkg::OP_DIFF: begin
        d_q  <= d_abs;
        lt_q <= x_lt_m;
      end
      rmv_pkg::OP_DIFF2: begin
        d2_q  <= d_abs;
        acc_q <= '0;
      end
      rmv_pkg::OP_MUL: acc_q <= acc_q + pp_sh;
      rmv_pkg::OP_OUT: begin
        if (!out_busy) begin
          cnt_out_q  <= rmv_pkg::COUNT_OUT_W'(count_q);
          mean_out_q <= mean_q;
          var_out_q  <= low_count ? '0 : div_quo;
          vv_out_q   <= !low_count;
          full_out_q <= full_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.valid           = out_valid_q;
  assign stat_o.sample_count    = cnt_out_q;
  assign stat_o.running_mean    = mean_out_q;
  assign stat_o.sample_variance = var_out_q;
  assign stat_o.variance_valid  = vv_out_q;
  assign stat_o.count_full      = full_out_q;

endmodule

// ----- sv/rmv_checker.sv -----
// Port-level checks for running_mean_variance_core, attached by bind.
// Depends on running_mean_variance_core_defines.svh and rmv_pkg.
`include "running_mean_variance_core_defines.svh"

module rmv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            samp_valid_i,
  input logic                            samp_ready_i,
  input logic                            stat_valid_i,
  input logic                            stat_ready_i,
  input logic [rmv_pkg::COUNT_OUT_W-1:0] sample_count_i,
  input logic [rmv_pkg::MEAN_W-1:0]      running_mean_i,
  input logic [rmv_pkg::VAR_W-1:0]       sample_variance_i,
  input logic                            variance_valid_i,
  input logic                            count_full_i
);

  localparam int FIELDS_W = rmv_pkg::COUNT_OUT_W + rmv_pkg::MEAN_W + rmv_pkg::VAR_W + 2;

  logic [FIELDS_W-1:0] stat_fields;

  assign stat_fields = {sample_count_i, running_mean_i, sample_variance_i,
                        variance_valid_i, count_full_i};

  `RMV_ASSERT_NEXT(a_stat_hold, stat_valid_i && !stat_ready_i, stat_valid_i)
  `RMV_ASSERT_NEXT(a_stat_stable, stat_valid_i && !stat_ready_i, $stable(stat_fields))
  `RMV_ASSERT_SAME(a_var_zero, stat_valid_i && !variance_valid_i, sample_variance_i == '0)
  `RMV_ASSERT_SAME(a_full_has_var, stat_valid_i && count_full_i, variance_valid_i)
  `RMV_ASSERT_NEXT(a_one_in_flight, samp_valid_i && samp_ready_i, !samp_ready_i)

endmodule

bind running_mean_variance_core rmv_checker u_rmv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .samp_valid_i      (samp_i.valid),
  .samp_ready_i      (samp_i.ready),
  .stat_valid_i      (stat_o.valid),
  .stat_ready_i      (stat_o.ready),
  .sample_count_i    (stat_o.sample_count),
  .running_mean_i    (stat_o.running_mean),
  .sample_variance_i (stat_o.sample_variance),
  .variance_valid_i  (stat_o.variance_valid),
  .count_full_i      (stat_o.count_full)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for running_mean_variance_core: directed and random sample streams
// checked against a Welford predictor held here. Needs rmv_pkg, rmv_if.sv and the core.
module tb;

  // narrow count so that the full-count case is reachable in a short run
  localparam int CNT_W       = 8;
  localparam int FRAC        = rmv_pkg::FRACTION_BITS_DEF;
  localparam int N_ITEMS     = 1450;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 200;

  localparam logic [63:0] CNT_MAX   = (64'd1 << CNT_W) - 64'd1;
  localparam logic [63:0] MEAN_MAX  = (64'd1 << rmv_pkg::MEAN_W) - 64'd1;
  localparam logic [63:0] SAMP_MASK = (64'd1 << rmv_pkg::SAMPLE_WIDTH_DEF) - 64'd1;

  typedef struct packed {
    logic [rmv_pkg::SAMPLE_W-1:0] sample;
    logic                         restart;
    logic                         settle;
  } sample_txn_t;

  typedef struct packed {
    logic [rmv_pkg::COUNT_OUT_W-1:0] sample_count;
    logic [rmv_pkg::MEAN_W-1:0]      running_mean;
    logic [rmv_pkg::VAR_W-1:0]       sample_variance;
    logic                            variance_valid;
    logic                            count_full;
  } stat_txn_t;

  logic clk_i;
  logic rst_ni;

  rmv_sample_if samp_if ();
  rmv_stat_if   stat_if ();

  running_mean_variance_core #(
    .COUNT_WIDTH (CNT_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp_if),
    .stat_o (stat_if)
  );

  logic [63:0] count_acc  = '0;
  logic [63:0] mean_acc   = '0;
  logic [63:0] sqsum_acc  = '0;

  sample_txn_t pending_q[$];
  stat_txn_t   stats_due_q[$];

  int unsigned n_taken     = 0;
  int unsigned n_offered   = 0;
  int unsigned n_results   = 0;
  int unsigned n_seen      = 0;
  int unsigned n_errors    = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap    = 0;
  int unsigned recv_stall  = 0;
  int unsigned n_restart   = 0;
  int unsigned n_full      = 0;
  int unsigned n_sat       = 0;
  int unsigned n_varvalid  = 0;
  bit          no_idle     = 1'b0;

  function automatic stat_txn_t welford_step(input logic [rmv_pkg::SAMPLE_W-1:0] sample,
                                             input logic restart);
    logic [63:0]  x;
    logic [63:0]  n;
    logic [63:0]  d;
    logic [63:0]  d2;
    logic [63:0]  m;
    logic [63:0]  psat;
    logic [127:0] prod;
    logic [64:0]  acc;
    stat_txn_t    r;
    x = (64'(sample) & SAMP_MASK) << FRAC;
    r.count_full = 1'b0;
    if (restart) begin
      count_acc = '0;
      mean_acc  = '0;
      sqsum_acc = '0;
    end
    if (count_acc >= CNT_MAX) begin
      r.count_full = 1'b1;
    end else begin
      n = count_acc + 64'd1;
      count_acc = n;
      if (x >= mean_acc) begin
        d = x - mean_acc;
        m = mean_acc + d / n;
        if (m > MEAN_MAX) m = MEAN_MAX;
        d2 = x - m;
      end else begin
        d  = mean_acc - x;
        m  = mean_acc - d / n;
        d2 = m - x;
      end
      mean_acc = m;
      prod = {64'd0, d} * {64'd0, d2};
      psat = (prod[127:64] != '0) ? '1 : prod[63:0];
      acc  = {1'b0, sqsum_acc} + {1'b0, psat};
      sqsum_acc = acc[64] ? '1 : acc[63:0];
    end
    r.sample_count = count_acc[rmv_pkg::COUNT_OUT_W-1:0];
    r.running_mean = mean_acc[rmv_pkg::MEAN_W-1:0];
    if (count_acc >= 64'd2) begin
      r.sample_variance = sqsum_acc / (count_acc - 64'd1);
      r.variance_valid  = 1'b1;
    end else begin
      r.sample_variance = '0;
      r.variance_valid  = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [rmv_pkg::SAMPLE_W-1:0] draw_sample(
      input logic [rmv_pkg::SAMPLE_W-1:0] base);
    logic [rmv_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1:    v = $urandom;
      2:       v = $urandom_range(0, 255);
      3:       v = 32'hFFFF_FFFF - $urandom_range(0, 255);
      4:       v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: v = base + $urandom_range(0, 1023);
    endcase
    return v;
  endfunction

  task automatic add_sample(input logic [rmv_pkg::SAMPLE_W-1:0] sample,
                            input logic restart, input logic settle);
    sample_txn_t t;
    t.sample  = sample;
    t.restart = restart;
    t.settle  = settle;
    pending_q = {pending_q, t};
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin : drive_samples
    sample_txn_t item;
    logic        next_valid;
    next_valid = samp_if.valid;
    if (!rst_ni) begin
      next_valid = 1'b0;
      samp_if.sample  <= '0;
      samp_if.restart <= 1'b0;
    end else begin
      if (samp_if.valid && n_taken == n_offered) begin
        next_valid = 1'b0;
        if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
        send_gap = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (!next_valid && pending_q.size() != 0) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!pending_q[0].settle || stats_due_q.size() == 0) begin
          item = pending_q.pop_front();
          samp_if.sample  <= item.sample;
          samp_if.restart <= item.restart;
          next_valid = 1'b1;
          n_offered++;
        end
      end
    end
    samp_if.valid <= next_valid;
  end

  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      stat_if.ready <= 1'b0;
    end else begin
      if (n_results != n_seen) begin
        n_seen     = n_results;
        recv_stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stat_if.valid && recv_stall != 0) recv_stall--;
      stat_if.ready <= (recv_stall == 0);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    stat_txn_t want;
    stat_txn_t got;
    if (rst_ni) begin
      idle_cycles++;
      if (stat_if.valid && stat_if.ready) begin
        idle_cycles = 0;
        n_results++;
        got.sample_count    = stat_if.sample_count;
        got.running_mean    = stat_if.running_mean;
        got.sample_variance = stat_if.sample_variance;
        got.variance_valid  = stat_if.variance_valid;
        got.count_full      = stat_if.count_full;
        if (stats_due_q.size() == 0) begin
          $error("result transaction with nothing expected: count %0d", got.sample_count);
          n_errors++;
        end else begin
          want = stats_due_q.pop_front();
          if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count,
                   got.sample_count);
            n_errors++;
          end
          if (got.running_mean !== want.running_mean) begin
            $error("running_mean: expected %0h, got %0h", want.running_mean,
                   got.running_mean);
            n_errors++;
          end
          if (got.sample_variance !== want.sample_variance) begin
            $error("sample_variance: expected %0h, got %0h", want.sample_variance,
                   got.sample_variance);
            n_errors++;
          end
          if (got.variance_valid !== want.variance_valid) begin
            $error("variance_valid: expected %0b, got %0b", want.variance_valid,
                   got.variance_valid);
            n_errors++;
          end
          if (got.count_full !== want.count_full) begin
            $error("count_full: expected %0b, got %0b", want.count_full, got.count_full);
            n_errors++;
          end
        end
      end
      if (samp_if.valid && samp_if.ready) begin
        idle_cycles = 0;
        n_taken++;
        want = welford_step(samp_if.sample, samp_if.restart);
        stats_due_q = {stats_due_q, want};
        if (samp_if.restart) n_restart++;
        if (want.count_full) n_full++;
        if (want.variance_valid) n_varvalid++;
        if (sqsum_acc == '1) n_sat++;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [rmv_pkg::SAMPLE_W-1:0] base;
    int unsigned                  len;
    int unsigned                  total;
    int unsigned                  seq;
    logic                         rs;
    logic                         settle;

    rst_ni = 1'b0;

    // first samples straight from reset, then the extremes
    add_sample(32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_sample(32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_sample(32'd5,         1'b1, 1'b0);
    add_sample(32'd5,         1'b0, 1'b0);
    add_sample(32'd7,         1'b0, 1'b0);
    add_sample(32'd3,         1'b0, 1'b0);
    add_sample(32'hAAAA_AAAA, 1'b1, 1'b1);
    add_sample(32'h5555_5555, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_sample(32'h0000_0000, 1'b1, 1'b0);
    add_sample(32'h0000_0001, 1'b0, 1'b0);
    add_sample(32'h0000_0000, 1'b0, 1'b0);
    add_sample(32'h8000_0000, 1'b0, 1'b0);
    add_sample(32'h0000_0001, 1'b1, 1'b0);

    // series with random content; the first runs past the count limit
    total = 0;
    seq   = 0;
    while (total < N_ITEMS) begin
      if (seq == 0 || $urandom_range(0, 24) == 0) len = 32'(CNT_MAX) + $urandom_range(1, 6);
      else len = $urandom_range(1, 30);
      base   = $urandom >> $urandom_range(0, 31);
      rs     = (seq <= 1) || ($urandom_range(0, 5) != 0);
      settle = (seq == 0) || ($urandom_range(0, 9) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if (i == 0) add_sample(draw_sample(base), rs, settle);
        else add_sample(draw_sample(base), $urandom_range(0, 39) == 0, 1'b0);
      end
      total += len;
      seq++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || n_taken != n_offered || stats_due_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d samples in %0d series, %0d restarts, %0d results checked.",
             n_taken, seq, n_restart, n_results);
    $display("Saw %0d full-count samples, %0d with variance valid, %0d at saturated sum.",
             n_full, n_varvalid, n_sat);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
